>>> sv/mcfm_pkg.sv
`default_nettype none

package mcfm_pkg;

  // Input item: command byte or end-of-data request
  typedef struct packed {
    logic       action;
    logic [7:0] command_byte;
  } in_t;

  // Result item: one FM register write
  typedef struct packed {
    logic [7:0] wait_ticks;
    logic [7:0] reg_address;
    logic [7:0] reg_value;
    logic       run_last;
  } out_t;

  // Command byte codes
  localparam logic [7:0] CMD_FRAME_END = 8'h00;
  localparam logic [7:0] CMD_NOTE_BASE = 8'h80;
  localparam logic [7:0] CMD_SONG_END  = 8'hC0;
  localparam logic [3:0] CMD_VOL_HI    = 4'hD;
  localparam logic [7:0] CMD_NOTE_OFF  = 8'hF8;
  localparam logic [6:0] NOTE_OFFSET   = 7'd36;

  // FM register map
  localparam logic [7:0] REG_FNUM_BASE  = 8'hA0;
  localparam logic [7:0] REG_KEY_BASE   = 8'hB0;
  localparam logic [7:0] REG_LEVEL_BASE = 8'h43;
  localparam logic [7:0] REG_END        = 8'hFF;
  localparam logic [5:0] MAX_LEVEL      = 6'd63;

  localparam logic [3:0] VOL_RESET = 4'd12;
  localparam logic [7:0] DELTA_MAX = 8'd255;

  // Work queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [1:0] {
    DESC_END,
    DESC_ON,
    DESC_OFF
  } desc_kind_t;

  // One unit of back-end work
  typedef struct packed {
    desc_kind_t kind;
    logic [1:0] ch;
    logic [7:0] delta;
    logic [3:0] vol;
    logic [6:0] note;
  } desc_t;

  typedef struct packed {
    logic [2:0] block;
    logic [9:0] fnum;
  } note_fn_t;

  // F-numbers of one octave at block 2
  function automatic logic [9:0] octave_rom(input logic [3:0] pc);
    logic [9:0] f;
    unique case (pc)
      4'd0:    f = 10'd516;
      4'd1:    f = 10'd547;
      4'd2:    f = 10'd580;
      4'd3:    f = 10'd614;
      4'd4:    f = 10'd651;
      4'd5:    f = 10'd689;
      4'd6:    f = 10'd730;
      4'd7:    f = 10'd774;
      4'd8:    f = 10'd820;
      4'd9:    f = 10'd869;
      4'd10:   f = 10'd920;
      4'd11:   f = 10'd975;
      default: f = 10'd0;
    endcase
    return f;
  endfunction

  // Note number to block and F-number; octave split by reciprocal multiply
  function automatic note_fn_t note_lookup(input logic [6:0] note);
    logic [7:0]  off;
    logic [15:0] prod;
    logic [3:0]  q;
    logic [3:0]  pc;
    logic [9:0]  f;
    note_fn_t    r;
    off  = {1'b0, note} + 8'd5;
    prod = 16'(off) * 16'd171;     // off / 12 for off < 256
    q    = prod[14:11];
    pc   = 4'(off - 8'(q) * 8'd12);
    f    = octave_rom(pc);
    if (q == 4'd0) begin
      r.fnum  = f >> 2;
      r.block = 3'd0;
    end else if (q == 4'd1) begin
      r.fnum  = f >> 1;
      r.block = 3'd0;
    end else if (q > 4'd9) begin
      // any left shift of an octave value overflows the field
      r.fnum  = 10'd1023;
      r.block = 3'd7;
    end else begin
      r.fnum  = f;
      r.block = 3'(q - 4'd2);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/music_cmd_to_fm_reg_writes.sv
`default_nettype none

// Channel  Dir  Handshake          Payload
// in       in   in_valid/in_ready  in_data   (mcfm_pkg::in_t: action, command_byte)
// out      out  out_valid/out_ready out_data (mcfm_pkg::out_t: delta, reg, value, run_last)
//
// The front takes one item per cycle while the work queue (4 entries) has room.
// Note on gives 4 writes, note off and end of data 1, other bytes none;
// the single write port of the back end sets the rate, so a note on holds it for all 4 writes.
// Reset is synchronous, active low: ticks 0, channel 0, volumes 12, notes 0.
// A stalled output holds its write; the front keeps accepting until the queue fills.

module music_cmd_to_fm_reg_writes import mcfm_pkg::*; #(
  parameter int NUM_CHANNELS = 3,
  parameter int TICK_BITS    = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic  q_full, q_push, q_pop, q_valid;
  desc_t q_wdata, q_head;

  mcfm_front #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .TICK_BITS    (TICK_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  mcfm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  mcfm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> sv/mcfm_front.sv
`default_nettype none

module mcfm_front import mcfm_pkg::*; #(
  parameter int NUM_CHANNELS = 3,
  parameter int TICK_BITS    = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire in_t   in_data,
  input  wire logic  q_full,
  output logic       q_push,
  output desc_t      q_data
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic [TICK_BITS-1:0] tick_r, tick_nxt;
  logic [TICK_BITS-1:0] last_r, last_nxt;
  logic [CH_W-1:0]      ch_r, ch_nxt;
  logic [3:0]           vol_r [NUM_CHANNELS];
  logic [6:0]           note_r [NUM_CHANNELS];
  logic                 ended_r, ended_nxt;

  logic                 accept;
  logic [7:0]           cmd;
  logic                 is_frame, is_pause, is_on, is_song_end, is_vol, is_off;
  logic [TICK_BITS-1:0] diff;
  logic [7:0]           delta_sat;
  logic [6:0]           new_note;
  logic [7:0]           tick_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cmd      = in_data.command_byte;

  // Classify the command byte
  always_comb begin
    is_frame    = 1'b0;
    is_pause    = 1'b0;
    is_on       = 1'b0;
    is_song_end = 1'b0;
    is_vol      = 1'b0;
    is_off      = 1'b0;
    if (!in_data.action && !ended_r) begin
      priority if (cmd == CMD_FRAME_END)             is_frame    = 1'b1;
      else if (!cmd[7])                              is_pause    = 1'b1;
      else if (cmd[7:6] == CMD_NOTE_BASE[7:6])       is_on       = 1'b1;
      else if (cmd == CMD_SONG_END)                  is_song_end = 1'b1;
      else if (cmd[7:4] == CMD_VOL_HI)               is_vol      = 1'b1;
      else if (cmd == CMD_NOTE_OFF)                  is_off      = 1'b1;
      else                                           is_frame    = 1'b0;  // effect or unknown
    end
  end

  // Saturated tick delta since the last note on or note off write
  assign diff      = tick_r - last_r;
  assign delta_sat = (diff[TICK_BITS-1:8] != '0) ? DELTA_MAX : diff[7:0];
  assign new_note  = 7'(cmd[5:0]) + NOTE_OFFSET;
  assign tick_inc  = is_frame ? 8'd1 : cmd;

  // State updates
  always_comb begin
    tick_nxt  = tick_r;
    last_nxt  = last_r;
    ch_nxt    = ch_r;
    ended_nxt = ended_r;
    if (accept) begin
      if (is_frame || is_pause) tick_nxt = tick_r + TICK_BITS'(tick_inc);
      if (is_frame) ch_nxt = (ch_r == CH_W'(NUM_CHANNELS - 1)) ? '0 : ch_r + 1'b1;
      if (is_on || is_off) last_nxt = tick_r;
      if (is_song_end) ended_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      last_r  <= '0;
      ch_r    <= '0;
      ended_r <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        vol_r[i]  <= VOL_RESET;
        note_r[i] <= '0;
      end
    end else begin
      tick_r  <= tick_nxt;
      last_r  <= last_nxt;
      ch_r    <= ch_nxt;
      ended_r <= ended_nxt;
      if (accept && is_vol) vol_r[ch_r] <= cmd[3:0];
      if (accept && is_on)  note_r[ch_r] <= new_note;
    end
  end

  // Work descriptor for the back end
  always_comb begin
    q_push       = accept && (in_data.action || is_on || is_off);
    q_data.ch    = 2'(ch_r);
    q_data.vol   = vol_r[ch_r];
    q_data.delta = delta_sat;
    q_data.note  = is_on ? new_note : note_r[ch_r];
    if (in_data.action)  q_data.kind = DESC_END;
    else if (is_on)      q_data.kind = DESC_ON;
    else                 q_data.kind = DESC_OFF;
  end

  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(ch_r) < NUM_CHANNELS)
    else $error("channel select out of range");

endmodule

`default_nettype wire

>>> sv/mcfm_queue.sv
`default_nettype none

module mcfm_queue import mcfm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire desc_t push_data,
  input  wire logic  pop,
  output logic       full,
  output logic       not_empty,
  output desc_t      head
);

  desc_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

>>> sv/mcfm_back.sv
`default_nettype none

module mcfm_back import mcfm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire desc_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_t       out_data
);

  desc_t      cur_r;
  note_fn_t   fn_r;
  logic       cur_valid_r;
  logic [1:0] step_r, step_nxt;
  out_t       out_r;
  logic       out_valid_r;

  logic       adv;
  logic       last_step;
  out_t       wr;
  logic [7:0] ch8;

  assign ch8       = 8'(cur_r.ch);
  assign last_step = (cur_r.kind != DESC_ON) || (step_r == 2'd3);
  assign adv       = cur_valid_r && (!out_valid_r || out_ready);
  assign q_pop     = q_valid && (!cur_valid_r || (adv && last_step));

  // Register write for the current step
  always_comb begin
    wr.wait_ticks  = 8'd0;
    wr.reg_address = REG_END;
    wr.reg_value   = 8'd0;
    wr.run_last    = last_step;
    unique case (cur_r.kind)
      DESC_END: ;
      DESC_OFF: begin
        wr.wait_ticks  = cur_r.delta;
        wr.reg_address = REG_KEY_BASE + ch8;
        wr.reg_value   = {3'b000, fn_r.block, fn_r.fnum[9:8]};
      end
      DESC_ON: begin
        unique case (step_r)
          2'd0: begin
            wr.wait_ticks  = cur_r.delta;
            wr.reg_address = REG_KEY_BASE + ch8;
          end
          2'd1: begin
            wr.reg_address = REG_LEVEL_BASE + ch8;
            wr.reg_value   = {2'b00, MAX_LEVEL - {cur_r.vol, 2'b00}};
          end
          2'd2: begin
            wr.reg_address = REG_FNUM_BASE + ch8;
            wr.reg_value   = fn_r.fnum[7:0];
          end
          2'd3: begin
            wr.reg_address = REG_KEY_BASE + ch8;
            wr.reg_value   = {3'b001, fn_r.block, fn_r.fnum[9:8]};
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (q_pop)    step_nxt = 2'd0;
    else if (adv) step_nxt = step_r + 2'd1;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (q_pop)                 cur_valid_r <= 1'b1;
      else if (adv && last_step) cur_valid_r <= 1'b0;
      if (adv)            out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
      fn_r  <= note_lookup(q_head.note);
    end
    if (adv) out_r <= wr;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_step_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_valid_r && step_r != 2'd0) |-> (cur_r.kind == DESC_ON))
    else $error("multi-step run on single-write item");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_r.run_last) |=> out_valid_r)
    else $error("write run broken before its last write");

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mcfm_pkg::*;

  // Command and action codes not named in the package
  localparam logic       ACT_BYTE          = 1'b0;
  localparam logic       ACT_END           = 1'b1;
  localparam logic [7:0] CMD_PAUSE_MAX     = 8'h7F;
  localparam logic [7:0] CMD_NOTE_LAST     = 8'hBF;
  localparam logic [7:0] CMD_EFFECT_FIRST  = 8'hC1;
  localparam logic [7:0] CMD_EFFECT_LAST   = 8'hCF;
  localparam logic [7:0] CMD_UNKNOWN_FIRST = 8'hE0;
  localparam logic [7:0] CMD_UNKNOWN_LAST  = 8'hFF;
  localparam logic [7:0] KEY_ON_BIT        = 8'h20;

  localparam int RANDOM_ITEMS   = 80;
  localparam int END_HOLDOFF    = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_PERIODIC,
    READY_COIN
  } ready_style_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  music_cmd_to_fm_reg_writes dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mirror of the block's state
  logic [31:0] tick_now;
  logic [31:0] tick_last_write;
  logic [1:0]  cur_chan;
  logic [3:0]  chan_vol [0:2];
  logic [6:0]  chan_note [0:2];
  logic        song_done;

  out_t pending_writes [$];
  int   error_count = 0;
  int   idle_cycles = 0;
  int   burst_left = 4;

  ready_style_t ready_style = READY_ALWAYS;
  int           ready_phase_left = 0;
  int           ready_tick = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // F-number of one octave at block 2
  function automatic int octave_fnum(input int pc);
    case (pc)
      0:       return 516;
      1:       return 547;
      2:       return 580;
      3:       return 614;
      4:       return 651;
      5:       return 689;
      6:       return 730;
      7:       return 774;
      8:       return 820;
      9:       return 869;
      10:      return 920;
      default: return 975;
    endcase
  endfunction

  // Shift the octave value by whole octaves, clamp block to 0..7 and F-number to 1023
  task automatic note_to_block_fnum(input logic [6:0] nn, output logic [2:0] blk,
                                    output logic [9:0] fn);
    int off;
    int oct;
    int f;
    off = int'(nn) + 5;
    oct = off / 12 - 2;
    f   = octave_fnum(off % 12);
    if (oct < 0) begin
      f   = f >> (-oct);
      oct = 0;
    end else if (oct > 7) begin
      f   = f << (oct - 7);
      oct = 7;
    end
    if (f > 1023) f = 1023;
    blk = 3'(oct);
    fn  = 10'(f);
  endtask

  // Ticks since the last write, saturated; marks this tick as written
  function automatic logic [7:0] delta_since_write();
    logic [31:0] diff;
    diff = tick_now - tick_last_write;
    tick_last_write = tick_now;
    return (diff > 32'd255) ? DELTA_MAX : diff[7:0];
  endfunction

  task automatic expect_write(input logic [7:0] d, input logic [7:0] a, input logic [7:0] v,
                              input logic l);
    pending_writes.push_back(out_t'{wait_ticks: d, reg_address: a, reg_value: v, run_last: l});
  endtask

  // Register writes caused by one accepted item
  task automatic compute_fm_writes(input in_t item);
    logic [7:0] cmd;
    logic [1:0] ch;
    logic [6:0] nn;
    logic [2:0] blk;
    logic [9:0] fn;
    logic [7:0] d;
    cmd = item.command_byte;
    ch  = cur_chan;
    if (item.action == ACT_END) begin
      expect_write(8'd0, REG_END, 8'd0, 1'b1);
    end else if (!song_done) begin
      if (cmd == CMD_FRAME_END) begin
        tick_now = tick_now + 32'd1;
        cur_chan = (ch == 2'd2) ? 2'd0 : ch + 2'd1;
      end else if (cmd <= CMD_PAUSE_MAX) begin
        tick_now = tick_now + {24'd0, cmd};
      end else if (cmd <= CMD_NOTE_LAST) begin
        nn = 7'(cmd - CMD_NOTE_BASE) + NOTE_OFFSET;
        note_to_block_fnum(nn, blk, fn);
        d = delta_since_write();
        expect_write(d, REG_KEY_BASE + 8'(ch), 8'd0, 1'b0);
        expect_write(8'd0, REG_LEVEL_BASE + 8'(ch),
                     8'(MAX_LEVEL) - {2'b00, chan_vol[ch], 2'b00}, 1'b0);
        expect_write(8'd0, REG_FNUM_BASE + 8'(ch), fn[7:0], 1'b0);
        expect_write(8'd0, REG_KEY_BASE + 8'(ch), {3'b000, blk, fn[9:8]} | KEY_ON_BIT, 1'b1);
        chan_note[ch] = nn;
      end else if (cmd == CMD_SONG_END) begin
        song_done = 1'b1;
      end else if (cmd[7:4] == CMD_VOL_HI) begin
        chan_vol[ch] = cmd[3:0];
      end else if (cmd == CMD_NOTE_OFF) begin
        note_to_block_fnum(chan_note[ch], blk, fn);
        d = delta_since_write();
        expect_write(d, REG_KEY_BASE + 8'(ch), {3'b000, blk, fn[9:8]}, 1'b1);
      end
    end
  endtask

  task automatic check_write(input out_t got);
    out_t want;
    if (pending_writes.size() == 0) begin
      report_mismatch($sformatf("write with nothing expected: %h", got));
    end else begin
      want = pending_writes.pop_front();
      if (got.wait_ticks !== want.wait_ticks)
        report_mismatch($sformatf("wait_ticks %h, expected %h", got.wait_ticks,
                                  want.wait_ticks));
      if (got.reg_address !== want.reg_address)
        report_mismatch($sformatf("reg_address %h, expected %h", got.reg_address,
                                  want.reg_address));
      if (got.reg_value !== want.reg_value)
        report_mismatch($sformatf("reg_value %h, expected %h (reg %h)", got.reg_value,
                                  want.reg_value, want.reg_address));
      if (got.run_last !== want.run_last)
        report_mismatch($sformatf("run_last %b, expected %b (reg %h)", got.run_last,
                                  want.run_last, want.reg_address));
    end
  endtask

  // Input and output monitor, plus watchdog on stalled handshakes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) compute_fm_writes(in_data);
      if (out_valid && out_ready) check_write(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Receiver stalls: one of four out_ready patterns, picked anew at random after each phase
  always @(posedge clk) begin
    ready_tick++;
    if (ready_phase_left == 0) begin
      ready_style = ready_style_t'($urandom_range(0, 3));
      ready_phase_left = $urandom_range(20, 80);
    end else begin
      ready_phase_left--;
    end
    case (ready_style)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_MOSTLY:   out_ready <= ($urandom_range(0, 3) != 0);
      READY_PERIODIC: out_ready <= (ready_tick % 7) < 3;
      default:        out_ready <= $urandom_range(0, 1);
    endcase
  end

  // Send one item; the sender idles between bursts of random length
  task automatic send_item(input in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_cmd(input logic [7:0] cmd);
    send_item(in_t'{action: ACT_BYTE, command_byte: cmd});
  endtask

  task automatic send_end(input logic [7:0] junk);
    send_item(in_t'{action: ACT_END, command_byte: junk});
  endtask

  // Hold input off until every expected write has come out
  task automatic drain_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  function automatic bit is_ignored(input in_t item);
    logic [7:0] c;
    c = item.command_byte;
    if (item.action == ACT_END) return 1'b0;
    return (c >= CMD_EFFECT_FIRST && c <= CMD_EFFECT_LAST) ||
           (c >= CMD_UNKNOWN_FIRST && c <= CMD_UNKNOWN_LAST && c != CMD_NOTE_OFF);
  endfunction

  // Mostly notes, rests and volume changes; song end is kept for the last test
  function automatic in_t random_item();
    in_t item;
    int  pick;
    item.action = ACT_BYTE;
    item.command_byte = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      item.command_byte = CMD_NOTE_BASE + 8'($urandom_range(0, 63));
    end else if (pick < 45) begin
      item.command_byte = CMD_NOTE_OFF;
    end else if (pick < 55) begin
      item.command_byte = CMD_FRAME_END;
    end else if (pick < 67) begin
      item.command_byte = 8'($urandom_range(1, 15));
    end else if (pick < 72) begin
      item.command_byte = 8'($urandom_range(16, 127));
    end else if (pick < 80) begin
      item.command_byte = {CMD_VOL_HI, 4'($urandom_range(0, 15))};
    end else if (pick < 86) begin
      item.action = ACT_END;
    end else if (pick < 90) begin
      item.command_byte = 8'($urandom_range(CMD_EFFECT_FIRST, CMD_EFFECT_LAST));
    end else if (pick < 94) begin
      item.command_byte = 8'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
    end else if (item.command_byte == CMD_SONG_END) begin
      item.command_byte = CMD_NOTE_OFF;
    end
    return item;
  endfunction

  // Every command class, volume and note extremes, channel rotation
  task automatic test_directed_commands();
    send_cmd(CMD_NOTE_OFF);                 // note off before any note on
    send_cmd(CMD_NOTE_BASE);                // lowest note, reset volume
    send_cmd({CMD_VOL_HI, 4'h0});
    send_cmd(CMD_NOTE_LAST);                // highest note, volume 0
    send_cmd({CMD_VOL_HI, 4'hF});
    send_cmd(CMD_NOTE_BASE + 8'd7);
    send_cmd(8'h01);
    send_cmd(CMD_PAUSE_MAX);
    send_cmd(CMD_FRAME_END);                // channel 1
    send_cmd(CMD_NOTE_OFF);
    send_cmd(8'h9A);
    send_cmd(CMD_FRAME_END);                // channel 2
    send_cmd(8'hA5);
    send_cmd(CMD_FRAME_END);                // wraps back to channel 0
    send_cmd(CMD_NOTE_OFF);
    send_cmd(CMD_EFFECT_FIRST);
    send_cmd(CMD_EFFECT_LAST);
    send_cmd(CMD_UNKNOWN_FIRST);
    send_cmd(8'hF7);
    send_cmd(8'hF9);
    send_cmd(CMD_UNKNOWN_LAST);
    send_end(8'h00);
    drain_writes();
  endtask

  // Long rests saturate the delta; back-to-back end markers
  task automatic test_delta_saturation();
    send_cmd(CMD_PAUSE_MAX);
    send_cmd(CMD_PAUSE_MAX);
    send_cmd(CMD_PAUSE_MAX);
    send_cmd(CMD_NOTE_OFF);
    send_cmd(8'h02);
    send_cmd(CMD_NOTE_BASE + 8'd20);
    send_end(8'hFF);
    send_end(8'h5A);
    drain_writes();
  endtask

  task automatic test_random_stream();
    in_t item;
    int  counted;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      item = random_item();
      send_item(item);
      if (!is_ignored(item)) counted++;
      if (counted == RANDOM_ITEMS / 2) begin
        drain_writes();
        counted++;
      end
    end
    drain_writes();
  endtask

  // After song end only end markers produce writes
  task automatic test_song_end();
    send_cmd(CMD_SONG_END);
    send_cmd(CMD_NOTE_BASE + 8'd12);
    send_cmd(CMD_NOTE_OFF);
    send_cmd(CMD_FRAME_END);
    send_cmd({CMD_VOL_HI, 4'h3});
    send_end(8'hC3);
    send_cmd(CMD_SONG_END);
    send_end(8'h00);
    send_end(8'hFF);
    repeat (10) send_item(random_item());
    send_cmd(CMD_NOTE_OFF);
    drain_writes();
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    tick_now        = '0;
    tick_last_write = '0;
    cur_chan        = '0;
    song_done       = 1'b0;
    for (int i = 0; i < 3; i++) begin
      chan_vol[i]  = VOL_RESET;
      chan_note[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_commands();
    test_delta_saturation();
    test_random_stream();
    test_song_end();

    repeat (END_HOLDOFF) @(posedge clk);
    if (pending_writes.size() != 0)
      report_mismatch($sformatf("%0d writes never came out", pending_writes.size()));
    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
